/* rtl/assert_macros.svh */
// Assertion macros for the queue RTL.
// Clock and reset names follow the project convention: clock, reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define FQD_ASSERT_ALWAYS(name, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define FQD_ASSERT_NEXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`endif

/* rtl/fqd_pkg.sv */
// Package for the FIFO queue with delete: sizes, opcodes, payload and
// controller/datapath interface types, pointer wrap helper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fqd_pkg;

   // Queue capacity and derived widths
   localparam int DEPTH    = 16;
   localparam int PTR_W    = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int SUM_W    = CNT_W + 1;
   localparam int ITEM_W   = 32;
   localparam int LENGTH_W = 5;
   localparam int OP_W     = 2;

   // Operation codes
   localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
   localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE  = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [ITEM_W-1:0] item_in;
   } fqd_req_type;

   typedef struct packed {
      logic                status;
      logic [ITEM_W-1:0]   item_out;
      logic [LENGTH_W-1:0] length;
   } fqd_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_FINISH
   } fqd_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;       // latch request, clear index, read front entry
      logic rd_next;    // read entry at index + 1
      logic idx_inc;    // advance scan index
      logic shift_wr;   // move read entry one place toward the front
      logic set_found;  // record a delete match
      logic commit;     // update queue state and load the result register
   } fqd_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            key_zero;
      logic            in_range;
      logic            match;
      logic            out_busy;
   } fqd_stat_type;

   // Ring buffer position head + off, with off no larger than DEPTH
   function automatic logic [PTR_W-1:0] fqd_wrap(input logic [PTR_W-1:0] head,
                                                 input logic [CNT_W-1:0] off);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(head) + SUM_W'(off);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return PTR_W'(sum);
   endfunction

endpackage

`default_nettype wire

/* rtl/fqd_ctrl.sv */
// Controller state machine for the FIFO queue with delete.
// Depends on fqd_pkg; drives datapath commands and the request stall.
`timescale 1ns / 1ps
`default_nettype none

module fqd_ctrl
   import fqd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output      logic         req_stall,
   input  wire fqd_stat_type stat,
   output      fqd_cmd_type  cmd
);

   fqd_state_type state_ff;
   fqd_state_type state_in;

   // Hold the state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Decide next state and issue datapath commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Only delete walks the queue; front entry is ready for dequeue
            if (stat.op != OP_DELETE || stat.key_zero || !stat.in_range) begin
               state_in = ST_FINISH;
            end else if (stat.match) begin
               cmd.set_found = 1'b1;
               cmd.rd_next   = 1'b1;
               cmd.idx_inc   = 1'b1;
               state_in      = ST_SHIFT;
            end else begin
               cmd.rd_next = 1'b1;
               cmd.idx_inc = 1'b1;
            end
         end
         ST_SHIFT: begin
            // Close up the gap one entry per cycle
            if (stat.in_range) begin
               cmd.shift_wr = 1'b1;
               cmd.rd_next  = 1'b1;
               cmd.idx_inc  = 1'b1;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!stat.out_busy) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/fqd_dpath.sv */
// Datapath for the FIFO queue with delete: ring buffer memory, pointers,
// scan index and result register. Depends on fqd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module fqd_dpath
   import fqd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire fqd_req_type  req_data,
   input  wire fqd_cmd_type  cmd,
   output      fqd_stat_type stat,
   output      logic         rsp_valid,
   input  wire logic         rsp_stall,
   output      fqd_rsp_type  rsp_data
);

   logic [ITEM_W-1:0] mem [DEPTH];

   logic [OP_W-1:0]   op_ff;
   logic [ITEM_W-1:0] key_ff;
   logic [CNT_W-1:0]  idx_ff;
   logic              found_ff;
   logic [PTR_W-1:0]  head_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [ITEM_W-1:0] rd_data_ff;
   logic              rsp_valid_ff;
   fqd_rsp_type       rsp_data_ff;

   logic [CNT_W-1:0]  idx_in;
   logic              found_in;
   logic [PTR_W-1:0]  head_in;
   logic [CNT_W-1:0]  count_in;
   logic              rsp_valid_in;
   fqd_rsp_type       rsp_data_in;

   logic              rd_en;
   logic [PTR_W-1:0]  rd_addr;
   logic              wr_en;
   logic [PTR_W-1:0]  wr_addr;
   logic [ITEM_W-1:0] wr_data;
   logic              enq_ok;
   logic              deq_ok;
   logic              del_ok;

   // Outcome of the held operation
   assign enq_ok = (op_ff == OP_ENQUEUE) && (key_ff != '0) && (count_ff < CNT_W'(DEPTH));
   assign deq_ok = (op_ff == OP_DEQUEUE) && (count_ff != '0);
   assign del_ok = (op_ff == OP_DELETE) && found_ff;

   // Select memory addresses: front on load, next entry while walking
   always_comb begin
      rd_en   = cmd.load || cmd.rd_next;
      rd_addr = cmd.load ? head_ff : fqd_wrap(head_ff, idx_ff + CNT_W'(1));
      wr_en   = 1'b0;
      wr_addr = fqd_wrap(head_ff, idx_ff - CNT_W'(1));
      wr_data = rd_data_ff;
      if (cmd.shift_wr) begin
         wr_en = 1'b1;
      end else if (cmd.commit && enq_ok) begin
         wr_en   = 1'b1;
         wr_addr = fqd_wrap(head_ff, count_ff);
         wr_data = key_ff;
      end
   end

   // Write and read the entry store
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Latch the request on transfer
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_data.op;
         key_ff <= req_data.item_in;
      end
   end

   // Advance index, pointers and the result register
   always_comb begin
      idx_in       = idx_ff;
      found_in     = found_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (cmd.load) begin
         idx_in   = '0;
         found_in = 1'b0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + CNT_W'(1);
      end
      if (cmd.set_found) begin
         found_in = 1'b1;
      end
      if (cmd.commit) begin
         if (enq_ok) begin
            count_in = count_ff + CNT_W'(1);
         end else if (deq_ok) begin
            count_in = count_ff - CNT_W'(1);
            head_in  = fqd_wrap(head_ff, CNT_W'(1));
         end else if (del_ok) begin
            count_in = count_ff - CNT_W'(1);
         end
         rsp_valid_in         = 1'b1;
         rsp_data_in.status   = !(enq_ok || deq_ok || del_ok);
         rsp_data_in.item_out = deq_ok ? rd_data_ff : '0;
         rsp_data_in.length   = LENGTH_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         found_ff     <= 1'b0;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         found_ff     <= found_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // Report status to the controller
   always_comb begin
      stat.op       = op_ff;
      stat.key_zero = (key_ff == '0);
      stat.in_range = (idx_ff < count_ff);
      stat.match    = (rd_data_ff == key_ff);
      stat.out_busy = rsp_valid_ff && rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `FQD_ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(DEPTH), "queue count above capacity")
   `FQD_ASSERT_ALWAYS(a_single_write, !(cmd.shift_wr && cmd.commit), "shift and commit collide")
   `FQD_ASSERT_ALWAYS(a_commit_free, !(cmd.commit && rsp_valid_ff && rsp_stall), "result overwritten")
   `FQD_ASSERT_NEXT(a_commit_shows, cmd.commit, rsp_valid_ff, "committed result not presented")

endmodule

`default_nettype wire

/* rtl/fifo_queue_with_delete_unit.sv */
// FIFO queue of nonzero 32-bit handles with enqueue, dequeue and delete by value.
// Enqueue and dequeue go from the transfer through the scan and finish states to
// the registered result. Delete walks the queue and moves one entry per cycle
// through one read and one write memory port, then finishes the same way.
// One item is in work at a time; a held result does not block the next transfer.
// Reset (synchronous) empties the queue; stored entries are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module fifo_queue_with_delete_unit
   import fqd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire fqd_req_type req_data,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      fqd_rsp_type rsp_data
);

   fqd_cmd_type  cmd;
   fqd_stat_type stat;

   // Sequence each operation
   fqd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Hold entries, pointers and the result
   fqd_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

/* tb/tb_fifo_queue_with_delete_unit.sv */
// Self-checking testbench for fifo_queue_with_delete_unit: directed and random
// enqueue/dequeue/delete traffic checked against a queue-based predictor.
// Depends on fqd_pkg for the sizes, opcodes and payload structs.
`timescale 1ns / 1ps

module tb_fifo_queue_with_delete_unit;
   import fqd_pkg::*;

   localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
   localparam int RANDOM_ITEMS  = 1750;
   localparam int PHASE_LEN     = 50;
   localparam int POOL_SIZE     = 12;
   localparam int IDLE_PCT      = 14;
   localparam int QUIET_FIRST   = 2000;
   localparam int QUIET_LAST    = 5000;
   localparam int HOLD_AT_RSP   = 600;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = DEPTH + 10;
   localparam real TIME_LIMIT_NS = 2_000_000.0;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   fqd_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   fqd_rsp_type rsp_data;

   fqd_req_type       pending_items[$];
   fqd_rsp_type       expected_rsps[$];
   logic [ITEM_W-1:0] handles_held[$];
   logic [ITEM_W-1:0] handle_pool[POOL_SIZE];

   int error_count = 0;
   int cycle_no    = 0;
   int taken_count = 0;
   int rsp_count   = 0;
   int offer_mark  = 0;
   int hold_left   = 0;
   bit hold_done   = 1'b0;

   fifo_queue_with_delete_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Clock and reset
   initial begin
      clock     = 1'b0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_stall = 1'b0;
      fork
         forever #2 clock = ~clock;
         begin
            repeat (4) @(posedge clock);
            @(negedge clock);
            reset <= 1'b0;
         end
      join_none
   end

   // Apply one operation to the shadow queue and return the result it gives
   function automatic fqd_rsp_type apply_request(input fqd_req_type r);
      fqd_rsp_type res;
      int hit;
      res        = '0;
      res.status = 1'b1;
      hit        = -1;
      case (r.op)
         OP_ENQUEUE: begin
            if (r.item_in != '0 && handles_held.size() < DEPTH) begin
               handles_held.push_back(r.item_in);
               res.status = 1'b0;
            end
         end
         OP_DEQUEUE: begin
            if (handles_held.size() > 0) begin
               res.item_out = handles_held.pop_front();
               res.status   = 1'b0;
            end
         end
         OP_DELETE: begin
            if (r.item_in != '0) begin
               // only the match nearest the front goes
               for (int i = 0; i < handles_held.size(); i++) begin
                  if (hit < 0 && handles_held[i] == r.item_in) hit = i;
               end
               if (hit >= 0) begin
                  handles_held.delete(hit);
                  res.status = 1'b0;
               end
            end
         end
         default: ;
      endcase
      res.length = LENGTH_W'(handles_held.size());
      return res;
   endfunction

   function automatic bit quiet_window();
      return cycle_no >= QUIET_FIRST && cycle_no < QUIET_LAST;
   endfunction

   function automatic bit idle_roll();
      return !quiet_window() && ($urandom_range(99) < IDLE_PCT);
   endfunction

   // Handle for a random item: mostly from a small pool so deletes hit
   function automatic logic [ITEM_W-1:0] pick_handle();
      int r;
      r = $urandom_range(99);
      if (r < 4) return '0;
      if (r < 24) return $urandom();
      return handle_pool[$urandom_range(POOL_SIZE - 1)];
   endfunction

   task automatic queue_request(input logic [OP_W-1:0] op, input logic [ITEM_W-1:0] item);
      fqd_req_type r;
      r.op      = op;
      r.item_in = item;
      pending_items.push_back(r);
   endtask

   // Stimulus: directed corner cases, then random phases with varying enqueue bias
   initial begin
      int enq_pct;
      int r;
      logic [OP_W-1:0] op;
      for (int i = 0; i < POOL_SIZE; i++) begin
         handle_pool[i] = $urandom() | 32'h1;
      end

      // empty-queue errors, reserved opcode, zero handles
      queue_request(OP_DEQUEUE, 32'hDEAD_BEEF);
      queue_request(OP_DELETE, 32'h0000_0001);
      queue_request(OP_RESERVED, 32'h1234_5678);
      queue_request(OP_ENQUEUE, 32'h0000_0000);
      queue_request(OP_DELETE, 32'h0000_0000);
      // fill to capacity with extreme and duplicated handles
      queue_request(OP_ENQUEUE, 32'hFFFF_FFFF);
      queue_request(OP_ENQUEUE, 32'h0000_0001);
      queue_request(OP_ENQUEUE, 32'h8000_0000);
      queue_request(OP_ENQUEUE, 32'h0000_0001);
      for (int i = 0; i < DEPTH - 4; i++) begin
         queue_request(OP_ENQUEUE, handle_pool[i % POOL_SIZE]);
      end
      // full, duplicate delete, missing delete, dequeue of the front
      queue_request(OP_ENQUEUE, 32'h5555_AAAA);
      queue_request(OP_DELETE, 32'h0000_0001);
      queue_request(OP_DELETE, 32'h7777_0000);
      queue_request(OP_DEQUEUE, 32'h0000_0000);

      enq_pct = 50;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % PHASE_LEN == 0) begin
            case ($urandom_range(2))
               0:       enq_pct = 72;
               1:       enq_pct = 48;
               default: enq_pct = 25;
            endcase
         end
         r = $urandom_range(99);
         if (r < 3) begin
            op = OP_RESERVED;
         end else if (r < enq_pct) begin
            op = OP_ENQUEUE;
         end else if ($urandom_range(1) == 0) begin
            op = OP_DEQUEUE;
         end else begin
            op = OP_DELETE;
         end
         queue_request(op, (op == OP_DEQUEUE || op == OP_RESERVED) ? $urandom() : pick_handle());
      end
   end

   // Driver: offer the head of the pending list, hold it until it transfers
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || taken_count != offer_mark) begin
         offer_mark = taken_count;
         if (pending_items.size() > 0 && !idle_roll()) begin
            req_valid <= 1'b1;
            req_data  <= pending_items[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result stall: random, plus one long hold-off to back the block up
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && rsp_count >= HOLD_AT_RSP) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= idle_roll();
      end
   end

   // Monitor: check each result transfer, then predict each request transfer
   always @(posedge clock) begin
      fqd_rsp_type want;
      if (!reset) begin
         cycle_no = cycle_no + 1;
         if (rsp_valid && !rsp_stall) begin
            rsp_count = rsp_count + 1;
            if (expected_rsps.size() == 0) begin
               $error("unexpected result transfer: status %0d item_out %h length %0d",
                      rsp_data.status, rsp_data.item_out, rsp_data.length);
               error_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
                  error_count++;
               end
               if (rsp_data.item_out !== want.item_out) begin
                  $error("item_out: expected %h, actual %h", want.item_out, rsp_data.item_out);
                  error_count++;
               end
               if (rsp_data.length !== want.length) begin
                  $error("length: expected %0d, actual %0d", want.length, rsp_data.length);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(apply_request(req_data));
            void'(pending_items.pop_front());
            taken_count = taken_count + 1;
         end
      end
   end

   // End of run: drain, let the block settle, then report
   initial begin
      wait (reset === 1'b0);
      wait (pending_items.size() == 0 && expected_rsps.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(TIME_LIMIT_NS);
      $display("DONE: errors detected");
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl
rtl/fqd_pkg.sv
rtl/fqd_ctrl.sv
rtl/fqd_dpath.sv
rtl/fifo_queue_with_delete_unit.sv
tb/tb_fifo_queue_with_delete_unit.sv
